/* hw/rtl/eafp_pkg.sv */
// Shared types and constants for the extent allocator.
package eafp_pkg;
	localparam int MaxExtents = 16;
	localparam int AddrWidth = 16;
	localparam int IdxWidth = $clog2(MaxExtents);
	localparam int CntWidth = $clog2(MaxExtents + 1);

	localparam logic [1:0] PolFirst = 2'd0;
	localparam logic [1:0] PolNext = 2'd1;
	localparam logic [1:0] PolBest = 2'd2;
	localparam logic [1:0] PolWorst = 2'd3;

	localparam logic KindAlloc = 1'b0;
	localparam logic KindFree = 1'b1;

	localparam logic [1:0] StatOk = 2'd0;
	localparam logic [1:0] StatNoFit = 2'd1;
	localparam logic [1:0] StatFull = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;   // capture the request
		logic scan_clr;   // reset the scan index and pick
		logic scan_step;  // examine one table entry
		logic alloc_upd;  // allocate update; the datapath does not read it
		logic free_upd;   // apply the allocate or free decision
		logic shift_step; // move one entry during insert or remove
		logic init;       // reinitialize the table
	} eafp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic need_shift;
	} eafp_sts_t;
endpackage

/* hw/rtl/eafp_if.sv */
// Valid/ready channel interfaces for requests and results.
interface eafp_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [1:0] policy;
	logic [15:0] length;
	logic [15:0] block_start;
	modport source (output valid, kind, policy, length, block_start, input ready);
	modport sink (input valid, kind, policy, length, block_start, output ready);
endinterface

interface eafp_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [15:0] start_address;
	modport source (output valid, status, start_address, input ready);
	modport sink (input valid, status, start_address, output ready);
endinterface

/* hw/rtl/eafp_ctrl.sv */
// Controller state machine that sequences scans and shifts.
module eafp_ctrl import eafp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_fire,
	input  logic       rsp_busy,
	input  logic       cfg_we,
	input  eafp_sts_t  sts,
	output eafp_cmd_t  cmd,
	output logic       req_ready,
	output logic       rsp_load
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StScan = 3'd1;
	localparam logic [2:0] StUpd = 3'd2;
	localparam logic [2:0] StShift = 3'd3;
	localparam logic [2:0] StDone = 3'd4;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= StIdle;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		rsp_load = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			StIdle: begin
				req_ready = !rsp_busy && !cfg_we;
				cmd.init = cfg_we;
				if (req_fire) begin
					cmd.load_req = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = StScan;
				end
			end
			StScan: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = StUpd;
			end
			StUpd: begin
				cmd.alloc_upd = 1'b1;
				cmd.free_upd = 1'b1;
				state_d = StShift;
			end
			StShift: begin
				// The shift decision is registered by the update cycle, so it is read here.
				cmd.shift_step = sts.need_shift;
				if (!sts.need_shift || sts.shift_done) state_d = StDone;
			end
			StDone: begin
				rsp_load = 1'b1;
				state_d = StIdle;
			end
			default: state_d = StIdle;
		endcase
	end
endmodule

/* hw/rtl/eafp_dp.sv */
// Datapath: free table, scan pick logic and shift unit.
module eafp_dp import eafp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eafp_cmd_t            cmd,
	input  logic [15:0]          cfg_data,
	input  logic                 in_kind,
	input  logic [1:0]           in_policy,
	input  logic [15:0]          in_length,
	input  logic [15:0]          in_block_start,
	output eafp_sts_t            sts,
	output logic [1:0]           res_status,
	output logic [AddrWidth-1:0] res_addr
);
	logic [AddrWidth-1:0] st_q [MaxExtents];
	logic [AddrWidth-1:0] ln_q [MaxExtents];
	logic [CntWidth-1:0] cnt_q;
	logic [AddrWidth-1:0] resume_q;

	logic kind_q;
	logic [1:0] pol_q;
	logic [AddrWidth-1:0] len_q, bs_q;

	// Scan state.
	logic [CntWidth-1:0] idx_q;
	logic [CntWidth-1:0] pick_q;   // primary pick (cnt = none)
	logic [CntWidth-1:0] wrap_q;   // next fit: first fit below resume point
	logic [CntWidth-1:0] pos_q;    // free: insert position
	logic found_pos_q;
	logic from_seen_q;             // next fit: resume point already reached

	// Shift state.
	logic shift_dir_q; // 1 = open a slot (insert), 0 = close (remove)
	logic [CntWidth-1:0] sh_q, sh_end_q;
	logic [1:0] status_q;
	logic [AddrWidth-1:0] addr_q;
	logic need_shift_q;

	logic [IdxWidth-1:0] idx_i, pick_i;
	logic scan_valid, fits, better, upper;
	assign idx_i = idx_q[IdxWidth-1:0];
	assign scan_valid = idx_q < cnt_q;
	assign fits = ln_q[idx_i] >= len_q;
	assign pick_i = pick_q[IdxWidth-1:0];
	// Every entry from the first one at or above the resume point is searched first.
	assign upper = from_seen_q || st_q[idx_i] >= resume_q;

	always_comb begin
		case (pol_q)
			PolBest: better = ln_q[idx_i] < ln_q[pick_i];
			PolWorst: better = ln_q[idx_i] > ln_q[pick_i];
			default: better = 1'b0;
		endcase
	end

	assign sts.scan_done = !scan_valid;
	assign sts.need_shift = need_shift_q;
	assign sts.shift_done = (sh_q == sh_end_q);
	assign res_status = status_q;
	assign res_addr = addr_q;

	// Free-merge decision values from the scan result.
	logic [CntWidth-1:0] p;
	logic [IdxWidth-1:0] pm1_i, p_i;
	logic has_prev, has_next, mp, mn;
	logic [AddrWidth:0] prev_end, bs_end, nl_a, nl_b;
	logic [AddrWidth-1:0] ns;
	assign p = pos_q;
	assign has_prev = p != '0;
	assign has_next = p < cnt_q;
	assign pm1_i = IdxWidth'(p - 1'b1);
	assign p_i = p[IdxWidth-1:0];
	assign prev_end = {1'b0, st_q[pm1_i]} + {1'b0, ln_q[pm1_i]};
	assign bs_end = {1'b0, bs_q} + {1'b0, len_q};
	assign nl_a = {1'b0, ln_q[pm1_i]} + {1'b0, len_q};
	assign mp = has_prev && prev_end == {1'b0, bs_q} && !nl_a[AddrWidth];
	assign nl_b = (mp ? nl_a : {1'b0, len_q}) + {1'b0, ln_q[p_i]};
	assign mn = has_next && bs_end == {1'b0, st_q[p_i]} && !nl_b[AddrWidth];
	assign ns = mp ? st_q[pm1_i] : bs_q;

	// Chosen allocation index.
	logic [CntWidth-1:0] choice;
	assign choice = (pol_q == PolNext && pick_q == cnt_q) ? wrap_q : pick_q;
	logic [IdxWidth-1:0] ch_i;
	assign ch_i = choice[IdxWidth-1:0];

	logic [IdxWidth-1:0] sh_i;
	assign sh_i = sh_q[IdxWidth-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CntWidth'(1);
			resume_q <= '0;
			st_q[0] <= '0;
			ln_q[0] <= 16'hFFFF;
			for (int i = 1; i < MaxExtents; i++) begin
				st_q[i] <= '0;
				ln_q[i] <= '0;
			end
			need_shift_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				st_q[0] <= '0;
				ln_q[0] <= cfg_data;
				cnt_q <= (cfg_data != '0) ? CntWidth'(1) : '0;
				resume_q <= '0;
			end
			if (cmd.free_upd) begin
				need_shift_q <= 1'b0;
				if (!kind_q) begin
					if (len_q == '0 || choice >= cnt_q) begin
						status_q <= StatNoFit;
						addr_q <= '0;
					end else begin
						status_q <= StatOk;
						addr_q <= st_q[ch_i];
						resume_q <= st_q[ch_i] + len_q;
						if (ln_q[ch_i] == len_q) begin
							need_shift_q <= 1'b1;
							shift_dir_q <= 1'b0;
							sh_q <= choice;
							sh_end_q <= cnt_q - 1'b1;
						end else begin
							st_q[ch_i] <= st_q[ch_i] + len_q;
							ln_q[ch_i] <= ln_q[ch_i] - len_q;
						end
					end
				end else begin
					status_q <= StatOk;
					addr_q <= '0;
					if (len_q == '0) begin
					end else if (mp) begin
						if (mn) begin
							ln_q[pm1_i] <= nl_b[AddrWidth-1:0];
							need_shift_q <= 1'b1;
							shift_dir_q <= 1'b0;
							sh_q <= p;
							sh_end_q <= cnt_q - 1'b1;
						end else begin
							ln_q[pm1_i] <= nl_a[AddrWidth-1:0];
						end
					end else if (mn) begin
						st_q[p_i] <= ns;
						ln_q[p_i] <= nl_b[AddrWidth-1:0];
					end else if (cnt_q >= CntWidth'(MaxExtents)) begin
						status_q <= StatFull;
					end else begin
						need_shift_q <= 1'b1;
						shift_dir_q <= 1'b1;
						sh_q <= cnt_q;
						sh_end_q <= p;
					end
				end
			end
			if (cmd.shift_step) begin
				if (shift_dir_q) begin
					if (sh_q == sh_end_q) begin
						st_q[sh_i] <= bs_q;
						ln_q[sh_i] <= len_q;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						st_q[sh_i] <= st_q[IdxWidth'(sh_q - 1'b1)];
						ln_q[sh_i] <= ln_q[IdxWidth'(sh_q - 1'b1)];
						sh_q <= sh_q - 1'b1;
					end
				end else begin
					if (sh_q == sh_end_q) begin
						st_q[sh_i] <= '0;
						ln_q[sh_i] <= '0;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						st_q[sh_i] <= st_q[IdxWidth'(sh_q + 1'b1)];
						ln_q[sh_i] <= ln_q[IdxWidth'(sh_q + 1'b1)];
						sh_q <= sh_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= in_kind;
			pol_q <= in_policy;
			len_q <= in_length;
			bs_q <= in_block_start;
		end
		if (cmd.scan_clr) begin
			idx_q <= '0;
			pick_q <= cnt_q;
			wrap_q <= cnt_q;
			pos_q <= cnt_q;
			found_pos_q <= 1'b0;
			from_seen_q <= 1'b0;
		end else if (cmd.scan_step && scan_valid) begin
			idx_q <= idx_q + 1'b1;
			if (upper) from_seen_q <= 1'b1;
			if (!found_pos_q && st_q[idx_i] >= bs_q) begin
				pos_q <= idx_q;
				found_pos_q <= 1'b1;
			end
			if (fits) begin
				case (pol_q)
					PolFirst: if (pick_q == cnt_q) pick_q <= idx_q;
					PolNext: begin
						if (upper) begin
							if (pick_q == cnt_q) pick_q <= idx_q;
						end else if (wrap_q == cnt_q) begin
							wrap_q <= idx_q;
						end
					end
					default: if (pick_q == cnt_q || better) pick_q <= idx_q;
				endcase
			end
		end
	end
endmodule

/* hw/rtl/extent_allocator_fit_policies.sv */
// Top level of the extent allocator with fit policies.
// One request at a time: the next transfer is taken only in idle, with no result waiting
// and no heap_size write. The table scan, one entry per cycle, and any entry shift come
// between a request transfer and its valid result.
// Reset gives one free extent of 65535 units; a heap_size write reinitializes it.
module extent_allocator_fit_policies import eafp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	eafp_req_if.sink    req,
	eafp_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	eafp_cmd_t cmd;
	eafp_sts_t sts;
	logic rsp_load, rsp_valid_q;
	logic [1:0] res_status, status_q;
	logic [AddrWidth-1:0] res_addr, addr_q;

	eafp_ctrl u_ctrl (
		.clk, .arst_n,
		.req_fire(req.valid && req.ready),
		.rsp_busy(rsp_valid_q && !rsp.ready),
		.cfg_we, .sts, .cmd,
		.req_ready(req.ready),
		.rsp_load
	);

	eafp_dp u_dp (
		.clk, .arst_n, .cmd, .cfg_data,
		.in_kind(req.kind), .in_policy(req.policy),
		.in_length(req.length), .in_block_start(req.block_start),
		.sts, .res_status, .res_addr
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (rsp_load) rsp_valid_q <= 1'b1;
		else if (rsp.ready) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q <= res_status;
			addr_q <= res_addr;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.start_address = addr_q;

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !req.ready)
		else $error("request taken while result waits");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !rsp_load)
		else $error("result loaded too early");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status != 2'd3)
		else $error("bad status");
endmodule
